// File: design/kvte_pkg.sv
// shared constants, codes and controller/datapath types for the key/value table engine
`default_nettype none
package kvte_pkg;

	// default sizes
	localparam int KVTE_DEPTH   = 16;
	localparam int KVTE_KEY_W   = 32;
	localparam int KVTE_VALUE_W = 32;

	// fixed field widths on the channels
	localparam int MODE_W      = 3;
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 4;
	localparam int STATUS_W    = 3;
	localparam int COUNT_OUT_W = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_KEYAT  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd6;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_WRITE0,
		S_UPDATE,
		S_READPOS,
		S_FINISH
	} kvte_state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic decide;
		logic sh_init_up;
		logic sh_init_dn;
		logic shift;
		logic write0;
		logic update;
		logic readpos;
		logic finish;
		logic count_dec;
	} kvte_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              op_ok;
		logic              scan_done;
		logic              shift_done;
		logic              out_free;
	} kvte_stat_t;

endpackage
`default_nettype wire

// File: design/kvte_if.sv
// request and response channel interfaces of the key/value table engine
`default_nettype none
interface kvte_req_if import kvte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_W-1:0]    key;
	logic [VALUE_W-1:0]  value_in;
	logic [POS_W-1:0]    position;

	modport source (output valid, output mode, output key, output value_in,
		output position, input ready);
	modport sink (input valid, input mode, input key, input value_in,
		input position, output ready);
endinterface

interface kvte_rsp_if import kvte_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic                   found;
	logic [VALUE_W-1:0]     value_out;
	logic [KEY_W-1:0]       key_out;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output status, output found, output value_out,
		output key_out, output entry_count, input ready);
	modport sink (input valid, input status, input found, input value_out,
		input key_out, input entry_count, output ready);
endinterface
`default_nettype wire

// File: design/kvte_ctrl.sv
// controller state machine: sequences search, shift, write and response per operation
`default_nettype none
module kvte_ctrl import kvte_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [MODE_W-1:0] req_mode,
	output logic                   req_ready,
	input  wire kvte_stat_t        stat,
	output kvte_cmd_t              cmd
);

	kvte_state_t state_q;
	kvte_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				// route on the mode of the incoming transfer, not the last captured one
				if (req_valid) begin
					if (req_mode <= MODE_FIND) state_d = S_SCAN;
					else state_d = S_DECIDE;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				if (stat.op_ok) begin
					priority if (stat.mode == MODE_ADD || stat.mode == MODE_DELETE) begin
						state_d = S_SHIFT;
					end else if (stat.mode == MODE_UPDATE) begin
						state_d = S_UPDATE;
					end else if (stat.mode == MODE_KEYAT) begin
						state_d = S_READPOS;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					if (stat.mode == MODE_ADD) state_d = S_WRITE0;
					else state_d = S_FINISH;
				end
			end
			S_WRITE0:  state_d = S_FINISH;
			S_UPDATE:  state_d = S_FINISH;
			S_READPOS: state_d = S_FINISH;
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_SCAN: cmd.scan = 1'b1;
			S_DECIDE: begin
				cmd.decide     = 1'b1;
				cmd.sh_init_up = stat.op_ok && (stat.mode == MODE_ADD);
				cmd.sh_init_dn = stat.op_ok && (stat.mode == MODE_DELETE);
			end
			S_SHIFT: begin
				cmd.shift     = 1'b1;
				cmd.count_dec = stat.shift_done && (stat.mode == MODE_DELETE);
			end
			S_WRITE0:  cmd.write0  = 1'b1;
			S_UPDATE:  cmd.update  = 1'b1;
			S_READPOS: cmd.readpos = 1'b1;
			S_FINISH:  cmd.finish  = stat.out_free;
		endcase
	end

endmodule
`default_nettype wire

// File: design/kvte_datapath.sv
// datapath: entry memory, search and shift pointers, fill count and response register
`default_nettype none
module kvte_datapath import kvte_pkg::*; #(
	parameter int TABLE_DEPTH = KVTE_DEPTH,
	parameter int KEY_WIDTH   = KVTE_KEY_W,
	parameter int VALUE_WIDTH = KVTE_VALUE_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kvte_cmd_t           cmd,
	output kvte_stat_t               stat,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [VALUE_W-1:0]  value_in,
	input  wire logic [POS_W-1:0]    position,
	kvte_rsp_if.source               rsp
);

	localparam int KeyW   = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
	localparam int ValW   = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
	localparam int EntW   = KeyW + ValW;
	localparam int AddrW  = $clog2(TABLE_DEPTH);
	localparam int CountW = $clog2(TABLE_DEPTH + 1);

	// operation registers
	logic [MODE_W-1:0]   mode_q;
	logic [KeyW-1:0]     key_q;
	logic [ValW-1:0]     val_q;
	logic [POS_W-1:0]    pos_q;
	logic [STATUS_W-1:0] status_q;

	logic [CountW-1:0]   count_q;

	// entry memory, {key, value}
	logic [EntW-1:0]     mem [TABLE_DEPTH];
	logic [EntW-1:0]     rdata_q;

	// search
	logic [CountW-1:0]   scan_issue_q;
	logic                chk_vld_q;
	logic [AddrW-1:0]    chk_idx_q;
	logic                hit_q;
	logic [AddrW-1:0]    at_q;
	logic [ValW-1:0]     hit_val_q;

	// shift
	logic                sh_up_q;
	logic [CountW-1:0]   sh_src_q;
	logic [CountW-1:0]   sh_rem_q;
	logic                sh_vld_q;
	logic [AddrW-1:0]    sh_dst_q;

	// response register
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic                   out_found_q;
	logic [VALUE_W-1:0]     out_value_q;
	logic [KEY_W-1:0]       out_key_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic [KeyW-1:0]             rd_key;
	logic [ValW-1:0]             rd_val;
	logic                        scan_more;
	logic                        scan_rd;
	logic                        hit_now;
	logic                        shift_rd;
	logic                        rd_en;
	logic [AddrW-1:0]            rd_addr;
	logic                        we;
	logic [AddrW-1:0]            waddr;
	logic [EntW-1:0]             wdata;
	logic [AddrW+POS_W-1:0]      pos_ext;
	logic [CountW+POS_W-1:0]     pos_wide;
	logic [CountW+POS_W-1:0]     cnt_wide;
	logic                        pos_ok;
	logic [STATUS_W-1:0]         status_c;
	logic [CountW-1:0]           at_wide;
	logic [CountW-1:0]           sh_src_inc;
	logic [CountW-1:0]           sh_src_dec;
	logic [ValW+VALUE_W-1:0]     val_ext;
	logic [KeyW+KEY_W-1:0]       key_ext;
	logic [CountW+COUNT_OUT_W-1:0] cnt_ext;

	assign rd_key    = rdata_q[EntW-1:ValW];
	assign rd_val    = rdata_q[ValW-1:0];
	assign scan_more = scan_issue_q < count_q;
	assign scan_rd   = cmd.scan && scan_more;
	assign hit_now   = cmd.scan && chk_vld_q && (rd_key == key_q);
	assign shift_rd  = cmd.shift && (sh_rem_q != '0);
	assign rd_en     = scan_rd || shift_rd || cmd.readpos;

	assign pos_ext  = {{AddrW{1'b0}}, pos_q};
	assign pos_wide = {{CountW{1'b0}}, pos_q};
	assign cnt_wide = {{POS_W{1'b0}}, count_q};
	assign pos_ok   = pos_wide < cnt_wide;

	assign at_wide    = CountW'(at_q);
	assign sh_src_inc = sh_src_q + 1'b1;
	assign sh_src_dec = sh_src_q - 1'b1;

	assign val_ext = {{VALUE_W{1'b0}}, hit_val_q};
	assign key_ext = {{KEY_W{1'b0}}, rd_key};
	assign cnt_ext = {{COUNT_OUT_W{1'b0}}, count_q};

	always_comb begin
		priority if (scan_rd) begin
			rd_addr = scan_issue_q[AddrW-1:0];
		end else if (shift_rd) begin
			rd_addr = sh_src_q[AddrW-1:0];
		end else begin
			rd_addr = pos_ext[AddrW-1:0];
		end
	end

	always_comb begin
		we = sh_vld_q || cmd.write0 || cmd.update;
		priority if (sh_vld_q) begin
			waddr = sh_dst_q;
			wdata = rdata_q;
		end else if (cmd.write0) begin
			waddr = '0;
			wdata = {key_q, val_q};
		end else begin
			waddr = at_q;
			wdata = {key_q, val_q};
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_ADD: begin
				if (hit_q) status_c = STAT_DUPLICATE;
				else if (count_q == CountW'(TABLE_DEPTH)) status_c = STAT_FULL;
				else status_c = STAT_OK;
			end
			MODE_GET, MODE_UPDATE, MODE_DELETE: begin
				status_c = hit_q ? STAT_OK : STAT_NOT_FOUND;
			end
			MODE_KEYAT: status_c = pos_ok ? STAT_OK : STAT_RANGE;
			default:    status_c = STAT_OK;
		endcase
	end

	always_comb begin
		stat.mode       = mode_q;
		stat.op_ok      = (status_c == STAT_OK);
		stat.scan_done  = hit_now || (!chk_vld_q && !scan_more);
		stat.shift_done = (sh_rem_q == '0) && !sh_vld_q;
		stat.out_free   = !out_valid_q || rsp.ready;
	end

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			chk_vld_q   <= 1'b0;
			hit_q       <= 1'b0;
			sh_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_q <= scan_rd;
			sh_vld_q  <= shift_rd;
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.write0) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q       <= mode;
			key_q        <= key[KeyW-1:0];
			val_q        <= value_in[ValW-1:0];
			pos_q        <= position;
			scan_issue_q <= '0;
		end else if (scan_rd) begin
			scan_issue_q <= scan_issue_q + 1'b1;
		end
		chk_idx_q <= scan_issue_q[AddrW-1:0];
		if (hit_now) begin
			at_q      <= chk_idx_q;
			hit_val_q <= rd_val;
		end
		if (cmd.decide) begin
			status_q <= status_c;
		end
		// add moves entries one place back, last entry first; delete pulls the tail forward
		if (cmd.sh_init_up) begin
			sh_up_q  <= 1'b1;
			sh_src_q <= count_q - 1'b1;
			sh_rem_q <= count_q;
		end else if (cmd.sh_init_dn) begin
			sh_up_q  <= 1'b0;
			sh_src_q <= at_wide + 1'b1;
			sh_rem_q <= count_q - at_wide - 1'b1;
		end else if (shift_rd) begin
			sh_src_q <= sh_up_q ? sh_src_dec : sh_src_inc;
			sh_rem_q <= sh_rem_q - 1'b1;
			sh_dst_q <= sh_up_q ? sh_src_inc[AddrW-1:0] : sh_src_dec[AddrW-1:0];
		end
		if (cmd.finish) begin
			out_status_q <= status_q;
			out_found_q  <= hit_q;
			out_value_q  <= (mode_q == MODE_GET && status_q == STAT_OK) ?
				val_ext[VALUE_W-1:0] : '0;
			out_key_q    <= (mode_q == MODE_KEYAT && status_q == STAT_OK) ?
				key_ext[KEY_W-1:0] : '0;
			out_count_q  <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.value_out   = out_value_q;
	assign rsp.key_out     = out_key_q;
	assign rsp.entry_count = out_count_q;

endmodule
`default_nettype wire

// File: design/key_value_table_engine_unit.sv
// top level of the key/value table engine: controller, datapath and channel hookup
// sequence: count and unused modes go from request transfer through decide to finish;
// key at position adds a position read; add, get, update, delete and find first search the table;
// add and delete then shift entries, add writes the new entry at slot 0 and update rewrites the hit
// throughput: one operation at a time; the entry memory reads one entry per cycle
// reset: arst_n clears the fill count and control state; entries are not cleared
`default_nettype none
module key_value_table_engine_unit import kvte_pkg::*; #(
	parameter int TABLE_DEPTH = KVTE_DEPTH,
	parameter int KEY_WIDTH   = KVTE_KEY_W,
	parameter int VALUE_WIDTH = KVTE_VALUE_W
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kvte_req_if.sink   req,
	kvte_rsp_if.source rsp
);

	kvte_cmd_t  cmd;
	kvte_stat_t stat;
	logic       req_ready;

	assign req.ready = req_ready;

	kvte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	kvte_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mode     (req.mode),
		.key      (req.key),
		.value_in (req.value_in),
		.position (req.position),
		.rsp      (rsp)
	);

	// busy right after a request transfer
	a_busy_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !req.ready)
		else $error("request accepted while an operation is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status <= STAT_RANGE))
		else $error("response status out of range");

	a_found_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> (rsp.status != STAT_NOT_FOUND && rsp.status != STAT_RANGE))
		else $error("found key reported as missing");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.value_out != '0) |-> (rsp.status == STAT_OK && rsp.found))
		else $error("value returned for a failed lookup");

endmodule
`default_nettype wire

// File: tb/key_value_table_engine_unit_checker.sv
// response checker for the key/value table engine: tracks the table and compares every response
`timescale 1ns / 1ps
module key_value_table_engine_unit_checker import kvte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	kvte_req_if         req,
	kvte_rsp_if         rsp,
	output int unsigned mismatches,
	output int unsigned awaited
);

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic                   found;
		logic [VALUE_W-1:0]     value_out;
		logic [KEY_W-1:0]       key_out;
		logic [COUNT_OUT_W-1:0] entry_count;
	} kv_answer_t;

	// shadow of the table, newest entry at slot 0
	logic [KEY_W-1:0]   shadow_keys   [KVTE_DEPTH];
	logic [VALUE_W-1:0] shadow_values [KVTE_DEPTH];
	int                 shadow_fill;
	kv_answer_t         answers_due [$];

	function automatic kv_answer_t apply_op(input logic [MODE_W-1:0] mode,
			input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] val,
			input logic [POS_W-1:0] pos);
		kv_answer_t ans;
		int         slot;
		bit         hit;
		ans  = '0;
		slot = shadow_fill;
		hit  = 1'b0;
		if (mode <= MODE_FIND) begin
			for (int i = 0; i < shadow_fill; i++) begin
				if (!hit && shadow_keys[i] == key) begin
					slot = i;
					hit  = 1'b1;
				end
			end
			ans.found = hit;
		end
		case (mode)
			MODE_ADD: begin
				if (hit) begin
					ans.status = STAT_DUPLICATE;
				end else if (shadow_fill >= KVTE_DEPTH) begin
					ans.status = STAT_FULL;
				end else begin
					for (int i = shadow_fill; i > 0; i--) begin
						shadow_keys[i]   = shadow_keys[i-1];
						shadow_values[i] = shadow_values[i-1];
					end
					shadow_keys[0]   = key;
					shadow_values[0] = val;
					shadow_fill++;
				end
			end
			MODE_GET: begin
				if (hit) ans.value_out = shadow_values[slot];
				else ans.status = STAT_NOT_FOUND;
			end
			MODE_UPDATE: begin
				if (hit) shadow_values[slot] = val;
				else ans.status = STAT_NOT_FOUND;
			end
			MODE_DELETE: begin
				if (hit) begin
					// close the gap, order of the rest stays
					for (int i = slot; i < shadow_fill - 1; i++) begin
						shadow_keys[i]   = shadow_keys[i+1];
						shadow_values[i] = shadow_values[i+1];
					end
					shadow_fill--;
				end else begin
					ans.status = STAT_NOT_FOUND;
				end
			end
			MODE_KEYAT: begin
				if (int'(pos) < shadow_fill) ans.key_out = shadow_keys[pos];
				else ans.status = STAT_RANGE;
			end
			default: begin
			end
		endcase
		ans.entry_count = shadow_fill[COUNT_OUT_W-1:0];
		return ans;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		awaited    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		kv_answer_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			answers_due.delete();
			awaited = 0;
		end else begin
			// a response transfer always belongs to an earlier request
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$error("response transfer with no request outstanding");
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("found", want.found, rsp.found);
					check_field("value_out", want.value_out, rsp.value_out);
					check_field("key_out", want.key_out, rsp.key_out);
					check_field("entry_count", want.entry_count, rsp.entry_count);
				end
			end
			if (req.valid && req.ready)
				answers_due.push_back(apply_op(req.mode, req.key, req.value_in, req.position));
			awaited = answers_due.size();
		end
	end

endmodule

// File: tb/key_value_table_engine_unit_tb.sv
// testbench top for the key/value table engine: clock, reset, request and response traffic, verdict
`timescale 1ns / 1ps
module key_value_table_engine_unit_tb;
	import kvte_pkg::*;

	// mode 7 has no name in the package and behaves as count
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
	localparam int RANDOM_OPS = 1200;
	localparam int POOL_SIZE  = 24;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned awaited;
	int unsigned sent;

	kvte_req_if req ();
	kvte_rsp_if rsp ();

	key_value_table_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	key_value_table_engine_unit_checker i_table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always #1 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	// one request transfer; valid stays high into the next call when no gap is drawn
	task automatic send_op(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] val, input logic [POS_W-1:0] pos);
		int unsigned gap;
		gap = ((sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.mode     <= mode;
		req.key      <= key;
		req.value_in <= val;
		req.position <= pos;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	initial begin : response_side
		int unsigned hold;
		int unsigned taken;
		taken = 0;
		rsp.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = ((taken / 64) % 4 == 2) ? 0 : $urandom_range(0, 17);
			// long hold-off so the engine backs up and stalls the request side
			if (taken == 300) hold = 600;
			if (hold != 0) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			taken++;
		end
	end

	initial begin : request_side
		logic [KEY_W-1:0]   key_pool [POOL_SIZE];
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] val;
		logic [MODE_W-1:0]  mode;
		int unsigned        add_pct;
		int unsigned        del_pct;
		int unsigned        pick;
		sent = 0;
		req.valid    <= 1'b0;
		req.mode     <= MODE_COUNT;
		req.key      <= '0;
		req.value_in <= '0;
		req.position <= '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
		wait (arst_n);
		@(posedge clk);

		// empty table corners
		send_op(MODE_COUNT, 32'h0, 32'h0, 4'd0);
		send_op(MODE_SPARE, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd0);
		send_op(MODE_GET, 32'h0, 32'h0, 4'd0);
		send_op(MODE_UPDATE, 32'h0, 32'h1, 4'd0);
		send_op(MODE_DELETE, 32'h0, 32'h0, 4'd0);
		send_op(MODE_FIND, 32'h0, 32'h0, 4'd0);
		// extremes of key and value, then a duplicate add
		send_op(MODE_ADD, 32'h0, 32'hffff_ffff, 4'd0);
		send_op(MODE_ADD, 32'hffff_ffff, 32'h0, 4'd0);
		send_op(MODE_ADD, 32'h0, 32'h1234_5678, 4'd0);
		send_op(MODE_ADD, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 4'd0);
		send_op(MODE_FIND, 32'hffff_ffff, 32'h0, 4'd0);
		send_op(MODE_GET, 32'h0, 32'h0, 4'd0);
		send_op(MODE_UPDATE, 32'hffff_ffff, 32'h1234_5678, 4'd0);
		send_op(MODE_GET, 32'hffff_ffff, 32'h0, 4'd0);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd0);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd2);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd3);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd15);
		// delete from the middle, order must close up
		send_op(MODE_DELETE, 32'hffff_ffff, 32'h0, 4'd0);
		send_op(MODE_KEYAT, 32'h0, 32'h0, 4'd1);
		send_op(MODE_COUNT, 32'h0, 32'h0, 4'd0);
		send_op(MODE_DELETE, 32'h0, 32'h0, 4'd0);
		send_op(MODE_DELETE, 32'h5a5a_5a5a, 32'h0, 4'd0);
		send_op(MODE_GET, 32'h5a5a_5a5a, 32'h0, 4'd0);

		// phases lean toward filling, mixing and draining the table
		for (int n = 0; n < RANDOM_OPS; n++) begin
			case ((n / 150) % 3)
				0: begin add_pct = 55; del_pct = 5; end
				1: begin add_pct = 25; del_pct = 20; end
				default: begin add_pct = 10; del_pct = 50; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < add_pct) begin
				mode = MODE_ADD;
			end else if (pick < add_pct + del_pct) begin
				mode = MODE_DELETE;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: mode = MODE_GET;
					3, 4:    mode = MODE_UPDATE;
					5, 6:    mode = MODE_FIND;
					7, 8:    mode = MODE_KEYAT;
					default: mode = $urandom_range(0, 1) ? MODE_COUNT : MODE_SPARE;
				endcase
			end
			key = ($urandom_range(0, 9) == 0) ? $urandom
				: key_pool[$urandom_range(0, POOL_SIZE - 1)];
			case ($urandom_range(0, 15))
				0:       val = '0;
				1:       val = '1;
				default: val = $urandom;
			endcase
			send_op(mode, key, val, 4'($urandom_range(0, 15)));
		end
		req.valid <= 1'b0;

		@(posedge clk);
		wait (awaited == 0);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/kvte_pkg.sv
design/kvte_if.sv
design/kvte_ctrl.sv
design/kvte_datapath.sv
design/key_value_table_engine_unit.sv
tb/key_value_table_engine_unit_checker.sv
tb/key_value_table_engine_unit_tb.sv
